/* src/caf_pkg.sv */
// Shared types and constants for the CAN acceptance filter bank.
// Used by caf_ctrl, caf_dpath and can_acceptance_filter_bank; no dependencies.
package caf_pkg;

    localparam int FILTER_SLOTS_DEF = 16;
    localparam int SLOT_W           = 4;
    localparam int IDENT_W          = 29;
    localparam int WORD_W           = 32;
    localparam int CLASS_W          = 2;
    localparam int MODE_W           = 2;
    localparam int CTRL_W           = 1 + MODE_W + CLASS_W;
    localparam int ENTRY_W          = CTRL_W + 2 * WORD_W;

    localparam logic [WORD_W-1:0] LIST_UNUSED_ID = 32'hFFFF_FFFF;

    localparam logic ITEM_WRITE = 1'b0;
    localparam logic ITEM_FRAME = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_MASK  = 2'd0,
        MODE_LIST  = 2'd1,
        MODE_RANGE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic load_frame;
        logic write_entry;
        logic step;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic scan_busy;
        logic blocked;
        logic out_free;
    } t_sts;

endpackage

/* src/caf_ram.sv */
// Generic single-write, single-read RAM with registered read and read enable.
// No dependencies.
module caf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/caf_ctrl.sv */
// Sequencing state machine for the filter bank: accept, scan, final result.
// Depends on caf_pkg.
module caf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  caf_pkg::t_sts i_sts,
    output caf_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    caf_pkg::t_state r_state;
    caf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= caf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            caf_pkg::ST_IDLE: begin
                if (i_in_valid && i_kind == caf_pkg::ITEM_FRAME) begin
                    n_state = caf_pkg::ST_SCAN;
                end
            end
            caf_pkg::ST_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = caf_pkg::ST_FINAL;
                end
            end
            caf_pkg::ST_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = caf_pkg::ST_IDLE;
                end
            end
            default: n_state = caf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            caf_pkg::ST_IDLE: begin
                o_in_stall        = 1'b0;
                o_cmd.load_frame  = i_in_valid && i_kind == caf_pkg::ITEM_FRAME;
                o_cmd.write_entry = i_in_valid && i_kind == caf_pkg::ITEM_WRITE;
            end
            caf_pkg::ST_SCAN: begin
                o_cmd.step = !i_sts.blocked;
            end
            caf_pkg::ST_FINAL: begin
                o_cmd.emit_final = i_sts.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

/* src/caf_dpath.sv */
// Datapath of the filter bank: entry RAM, written flags, scan pipeline,
// pending hit and output register. Depends on caf_pkg and caf_ram.
module caf_dpath #(
    parameter int FILTER_SLOTS = caf_pkg::FILTER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  caf_pkg::t_cmd                 i_cmd,
    output caf_pkg::t_sts                 o_sts,
    input  logic [caf_pkg::SLOT_W-1:0]    i_entry_slot,
    input  logic                          i_entry_enabled,
    input  logic [caf_pkg::MODE_W-1:0]    i_entry_mode,
    input  logic [caf_pkg::CLASS_W-1:0]   i_entry_frame_kind,
    input  logic [caf_pkg::WORD_W-1:0]    i_entry_word_a,
    input  logic [caf_pkg::WORD_W-1:0]    i_entry_word_b,
    input  logic [caf_pkg::IDENT_W-1:0]   i_frame_ident,
    input  logic [caf_pkg::CLASS_W-1:0]   i_frame_class,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic [caf_pkg::SLOT_W-1:0]    o_hit_slot,
    output logic                          o_last_of_run
);

    localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
    localparam int EXT_W = (IDX_W > caf_pkg::SLOT_W) ? IDX_W : caf_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_SLOTS - 1);

    logic [EXT_W-1:0]                 wr_ext;
    logic [IDX_W-1:0]                 wr_idx;
    logic                             wr_ok;
    logic                             ram_we;
    logic                             ram_re;
    logic [caf_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [caf_pkg::ENTRY_W-1:0]      ram_rdata;

    logic [FILTER_SLOTS-1:0]          r_ent_vld;
    logic [IDX_W-1:0]                 r_rd_idx;
    logic                             r_rd_live;
    logic                             r_tst_vld;
    logic [IDX_W-1:0]                 r_tst_idx;
    logic                             r_pend_vld;
    logic [IDX_W-1:0]                 r_pend_idx;
    logic [caf_pkg::WORD_W-1:0]       r_ident;
    logic [caf_pkg::CLASS_W-1:0]      r_class;
    logic                             r_out_vld;
    logic                             r_out_hit;
    logic [caf_pkg::SLOT_W-1:0]       r_out_slot;
    logic                             r_out_last;

    logic [caf_pkg::CTRL_W-1:0]       tst_ctrl;
    logic [caf_pkg::WORD_W-1:0]       tst_a;
    logic [caf_pkg::WORD_W-1:0]       tst_b;
    caf_pkg::t_mode                   tst_mode;
    logic                             mode_hit;
    logic                             hit;
    logic                             out_free;
    logic                             blocked;
    logic                             advance;
    logic                             emit_mid;
    logic [EXT_W-1:0]                 pend_ext;

    assign wr_ext    = EXT_W'(i_entry_slot);
    assign wr_idx    = wr_ext[IDX_W-1:0];
    assign wr_ok     = int'(i_entry_slot) < FILTER_SLOTS;
    assign ram_we    = i_cmd.write_entry && wr_ok;
    assign ram_wdata = {i_entry_frame_kind, i_entry_mode, i_entry_enabled,
                        i_entry_word_b, i_entry_word_a};

    caf_ram #(
        .WIDTH (caf_pkg::ENTRY_W),
        .DEPTH (FILTER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign tst_ctrl = ram_rdata[caf_pkg::ENTRY_W-1 -: caf_pkg::CTRL_W];
    assign tst_a    = ram_rdata[caf_pkg::WORD_W-1:0];
    assign tst_b    = ram_rdata[2*caf_pkg::WORD_W-1:caf_pkg::WORD_W];
    assign tst_mode = caf_pkg::t_mode'(tst_ctrl[2:1]);

    always_comb begin
        unique case (tst_mode)
            caf_pkg::MODE_MASK:  mode_hit = (r_ident & tst_a) == (tst_b & tst_a);
            caf_pkg::MODE_LIST:  mode_hit = (r_ident == tst_a) ||
                                            (tst_b != caf_pkg::LIST_UNUSED_ID &&
                                             r_ident == tst_b);
            caf_pkg::MODE_RANGE: mode_hit = (r_ident >= tst_a) && (r_ident <= tst_b);
            default:             mode_hit = 1'b0;
        endcase
    end

    assign hit = r_tst_vld && r_ent_vld[r_tst_idx] && tst_ctrl[0] &&
                 tst_ctrl[4:3] == r_class && mode_hit;

    assign out_free = !r_out_vld || !i_out_stall;
    assign blocked  = hit && r_pend_vld && !out_free;
    assign advance  = i_cmd.step && !blocked;
    assign ram_re   = advance && r_rd_live;
    assign emit_mid = advance && hit && r_pend_vld;
    assign pend_ext = EXT_W'(r_pend_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld  <= '0;
            r_rd_live  <= 1'b0;
            r_tst_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (ram_we) begin
                r_ent_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.load_frame) begin
                r_rd_live  <= 1'b1;
                r_tst_vld  <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (advance) begin
                r_tst_vld <= r_rd_live;
                if (r_rd_live && r_rd_idx == LAST_IDX) begin
                    r_rd_live <= 1'b0;
                end
                if (hit) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (emit_mid || i_cmd.emit_final) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_frame) begin
            r_rd_idx <= '0;
            r_ident  <= caf_pkg::WORD_W'(i_frame_ident);
            r_class  <= i_frame_class;
        end else if (advance) begin
            if (r_rd_live) begin
                r_tst_idx <= r_rd_idx;
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (hit) begin
                r_pend_idx <= r_tst_idx;
            end
        end
        if (emit_mid) begin
            r_out_hit  <= 1'b1;
            r_out_slot <= pend_ext[caf_pkg::SLOT_W-1:0];
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_hit  <= r_pend_vld;
            r_out_slot <= r_pend_vld ? pend_ext[caf_pkg::SLOT_W-1:0] : '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_sts.scan_busy = r_rd_live || r_tst_vld;
    assign o_sts.blocked   = blocked;
    assign o_sts.out_free  = out_free;

    assign o_out_valid   = r_out_vld;
    assign o_hit         = r_out_hit;
    assign o_hit_slot    = r_out_slot;
    assign o_last_of_run = r_out_last;

endmodule

/* src/can_acceptance_filter_bank.sv */
// CAN acceptance filter bank, top level. Depends on caf_pkg, caf_ctrl, caf_dpath.
// After a filter write the next item is accepted in the following cycle.
// A frame scans one entry per cycle while no earlier hit waits on a stalled output;
// the next item is accepted once the frame's final result is in the output register.
// The entry RAM read port and the scan counter step the scan through the slots.
// Synchronous active-low reset marks every entry unwritten (disabled) at once.
module can_acceptance_filter_bank #(
    parameter int FILTER_SLOTS = caf_pkg::FILTER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [caf_pkg::SLOT_W-1:0]    i_entry_slot,
    input  logic                          i_entry_enabled,
    input  logic [caf_pkg::MODE_W-1:0]    i_entry_mode,
    input  logic [caf_pkg::CLASS_W-1:0]   i_entry_frame_kind,
    input  logic [caf_pkg::WORD_W-1:0]    i_entry_word_a,
    input  logic [caf_pkg::WORD_W-1:0]    i_entry_word_b,
    input  logic [caf_pkg::IDENT_W-1:0]   i_frame_ident,
    input  logic [caf_pkg::CLASS_W-1:0]   i_frame_class,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [caf_pkg::SLOT_W-1:0]    o_hit_slot,
    output logic                          o_last_of_run
);

    caf_pkg::t_cmd cmd;
    caf_pkg::t_sts sts;

    caf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    caf_dpath #(
        .FILTER_SLOTS (FILTER_SLOTS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_entry_slot       (i_entry_slot),
        .i_entry_enabled    (i_entry_enabled),
        .i_entry_mode       (i_entry_mode),
        .i_entry_frame_kind (i_entry_frame_kind),
        .i_entry_word_a     (i_entry_word_a),
        .i_entry_word_b     (i_entry_word_b),
        .i_frame_ident      (i_frame_ident),
        .i_frame_class      (i_frame_class),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_hit              (o_hit),
        .o_hit_slot         (o_hit_slot),
        .o_last_of_run      (o_last_of_run)
    );

    a_frame_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == caf_pkg::ITEM_FRAME |=> o_in_stall)
        else $error("input not held after frame acceptance");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == caf_pkg::ITEM_WRITE |=> !o_in_stall)
        else $error("filter write did not complete in one cycle");

    a_miss_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_last_of_run && o_hit_slot == '0)
        else $error("miss result not marked final or slot nonzero");

endmodule

/* bench/tb_can_acceptance_filter_bank.sv */
// Testbench for can_acceptance_filter_bank: loads filter entries and presents frames
// over valid/stall, predicts the hit list of every frame and checks each result.
// Depends on caf_pkg and the can_acceptance_filter_bank RTL.
module tb_can_acceptance_filter_bank;

    localparam int FILTER_SLOTS = caf_pkg::FILTER_SLOTS_DEF;
    localparam int SLOT_W       = caf_pkg::SLOT_W;
    localparam int IDENT_W      = caf_pkg::IDENT_W;
    localparam int WORD_W       = caf_pkg::WORD_W;
    localparam int CLASS_W      = caf_pkg::CLASS_W;
    localparam int MODE_W       = caf_pkg::MODE_W;
    localparam int MAX_HITS     = 16;
    localparam int MAX_CYCLES   = 400000;
    localparam int DRAIN_CYCLES = FILTER_SLOTS + 8;
    localparam int RANDOM_OPS   = 340;
    localparam int REPORT_LIMIT = 10;

    localparam logic [WORD_W-1:0]  LIST_UNUSED   = caf_pkg::LIST_UNUSED_ID;
    localparam logic [WORD_W-1:0]  IDENT_MASK    = 32'h1FFF_FFFF;
    localparam logic [CLASS_W-1:0] KIND_STD_DATA = 2'd0;
    localparam logic [CLASS_W-1:0] KIND_EXT_DATA = 2'd1;
    localparam logic [CLASS_W-1:0] KIND_STD_RTR  = 2'd2;
    localparam logic [CLASS_W-1:0] KIND_EXT_RTR  = 2'd3;

    typedef struct packed {
        logic               on;
        caf_pkg::t_mode     mode;
        logic [CLASS_W-1:0] fclass;
        logic [WORD_W-1:0]  word_a;
        logic [WORD_W-1:0]  word_b;
    } t_filt_entry;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_match;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic               en;
        logic [MODE_W-1:0]  mode;
        logic [CLASS_W-1:0] fkind;
        logic [WORD_W-1:0]  word_a;
        logic [WORD_W-1:0]  word_b;
        logic [IDENT_W-1:0] ident;
        logic [CLASS_W-1:0] fclass;
        logic [3:0]         gap;
        logic               drain;
    } t_bank_op;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_kind;
    logic [SLOT_W-1:0]   i_entry_slot;
    logic                i_entry_enabled;
    logic [MODE_W-1:0]   i_entry_mode;
    logic [CLASS_W-1:0]  i_entry_frame_kind;
    logic [WORD_W-1:0]   i_entry_word_a;
    logic [WORD_W-1:0]   i_entry_word_b;
    logic [IDENT_W-1:0]  i_frame_ident;
    logic [CLASS_W-1:0]  i_frame_class;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_hit_slot;
    logic                o_last_of_run;

    t_filt_entry         filt_tab [FILTER_SLOTS];
    t_match              match_q [$];
    t_bank_op            bank_ops [$];
    t_bank_op            cur_op;

    logic [WORD_W-1:0]   gen_a    [FILTER_SLOTS];
    logic [WORD_W-1:0]   gen_b    [FILTER_SLOTS];
    logic [CLASS_W-1:0]  gen_kind [FILTER_SLOTS];

    int cycles, mismatches, ops_total, ops_taken;
    int writes_seen, frames_seen, results_seen, hits_seen, most_hits;
    int gap_left, stall_left;
    bit have_op, in_taken, out_taken, in_next, quiet_in, next_drain;

    can_acceptance_filter_bank #(
        .FILTER_SLOTS(FILTER_SLOTS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_entry_slot       (i_entry_slot),
        .i_entry_enabled    (i_entry_enabled),
        .i_entry_mode       (i_entry_mode),
        .i_entry_frame_kind (i_entry_frame_kind),
        .i_entry_word_a     (i_entry_word_a),
        .i_entry_word_b     (i_entry_word_b),
        .i_frame_ident      (i_frame_ident),
        .i_frame_class      (i_frame_class),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_hit_slot         (o_hit_slot),
        .o_last_of_run      (o_last_of_run)
    );

    function automatic void scan_frame(input logic [IDENT_W-1:0] ident,
                                       input logic [CLASS_W-1:0] fclass);
        logic [WORD_W-1:0] id32;
        t_filt_entry       e;
        t_match            m;
        logic              hit;
        int                found;
        id32  = {{(WORD_W - IDENT_W){1'b0}}, ident};
        found = 0;
        for (int s = 0; s < FILTER_SLOTS; s++) begin
            e   = filt_tab[s];
            hit = 1'b0;
            if (e.on && e.fclass == fclass) begin
                case (e.mode)
                    caf_pkg::MODE_MASK:
                        hit = (id32 & e.word_a) == (e.word_b & e.word_a);
                    caf_pkg::MODE_LIST:
                        hit = id32 == e.word_a ||
                              (e.word_b != LIST_UNUSED && id32 == e.word_b);
                    caf_pkg::MODE_RANGE:
                        hit = id32 >= e.word_a && id32 <= e.word_b;
                    default:
                        hit = 1'b0;
                endcase
            end
            if (hit && found < MAX_HITS) begin
                m.hit  = 1'b1;
                m.slot = s[SLOT_W-1:0];
                m.last = 1'b0;
                match_q.push_back(m);
                found++;
            end
        end
        if (found == 0) begin
            m.hit  = 1'b0;
            m.slot = '0;
            m.last = 1'b1;
            match_q.push_back(m);
        end else begin
            m      = match_q.pop_back();
            m.last = 1'b1;
            match_q.push_back(m);
        end
        if (found > most_hits)
            most_hits = found;
    endfunction

    function automatic void queue_op(input t_bank_op op_in);
        t_bank_op op;
        op       = op_in;
        op.gap   = quiet_in ? 4'd0 : 4'($urandom_range(0, 11));
        op.drain = next_drain;
        next_drain = 1'b0;
        bank_ops.push_back(op);
        ops_total++;
    endfunction

    function automatic void push_write(input logic [SLOT_W-1:0] slot, input logic en,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [CLASS_W-1:0] fkind,
                                       input logic [WORD_W-1:0] wa,
                                       input logic [WORD_W-1:0] wb);
        t_bank_op op;
        op        = '0;
        op.kind   = caf_pkg::ITEM_WRITE;
        op.slot   = slot;
        op.en     = en;
        op.mode   = mode;
        op.fkind  = fkind;
        op.word_a = wa;
        op.word_b = wb;
        op.ident  = IDENT_W'($urandom);
        op.fclass = CLASS_W'($urandom);
        gen_a[slot]    = wa;
        gen_b[slot]    = wb;
        gen_kind[slot] = fkind;
        queue_op(op);
    endfunction

    function automatic void push_frame(input logic [IDENT_W-1:0] ident,
                                       input logic [CLASS_W-1:0] fclass);
        t_bank_op op;
        op        = '0;
        op.kind   = caf_pkg::ITEM_FRAME;
        op.slot   = SLOT_W'($urandom);
        op.en     = 1'($urandom);
        op.mode   = MODE_W'($urandom);
        op.fkind  = CLASS_W'($urandom);
        op.word_a = $urandom;
        op.word_b = $urandom;
        op.ident  = ident;
        op.fclass = fclass;
        queue_op(op);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // input driver: present the next pending transaction once the previous one is taken
    always @(negedge i_clk) begin
        in_next = i_in_valid && !in_taken;
        if (i_rst_n && !in_next) begin
            if (!have_op && bank_ops.size() != 0) begin
                cur_op   = bank_ops.pop_front();
                have_op  = 1'b1;
                gap_left = cur_op.gap;
            end
            if (have_op) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!cur_op.drain || match_q.size() == 0) begin
                    i_kind             <= cur_op.kind;
                    i_entry_slot       <= cur_op.slot;
                    i_entry_enabled    <= cur_op.en;
                    i_entry_mode       <= cur_op.mode;
                    i_entry_frame_kind <= cur_op.fkind;
                    i_entry_word_a     <= cur_op.word_a;
                    i_entry_word_b     <= cur_op.word_b;
                    i_frame_ident      <= cur_op.ident;
                    i_frame_class      <= cur_op.fclass;
                    in_next = 1'b1;
                    have_op = 1'b0;
                end
            end
        end
        i_in_valid <= in_next;
    end

    // result receiver: hold stall for a drawn number of valid cycles per result
    always @(negedge i_clk) begin
        if (out_taken)
            stall_left = (results_seen % 48) >= 36 ? 0 : $urandom_range(0, 11);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            if (o_out_valid)
                stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_filt_entry new_entry;
        t_match      want;
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, match_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            in_taken  = i_rst_n && i_in_valid && !o_in_stall;
            out_taken = i_rst_n && o_out_valid && !i_out_stall;
            if (out_taken) begin
                results_seen++;
                if (o_hit)
                    hits_seen++;
                if (match_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("cycle %0d: unexpected result hit=%0b slot=%0d last=%0b",
                                 cycles, o_hit, o_hit_slot, o_last_of_run);
                end else begin
                    want = match_q.pop_front();
                    if (o_hit !== want.hit || o_hit_slot !== want.slot ||
                        o_last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("cycle %0d: expected %0b/%0d/%0b got %0b/%0d/%0b",
                                     cycles, want.hit, want.slot, want.last,
                                     o_hit, o_hit_slot, o_last_of_run);
                    end
                end
            end
            if (in_taken) begin
                ops_taken++;
                if (i_kind == caf_pkg::ITEM_WRITE) begin
                    writes_seen++;
                    new_entry.on     = i_entry_enabled;
                    new_entry.mode   = caf_pkg::t_mode'(i_entry_mode);
                    new_entry.fclass = i_entry_frame_kind;
                    new_entry.word_a = i_entry_word_a;
                    new_entry.word_b = i_entry_word_b;
                    if (i_entry_slot < FILTER_SLOTS)
                        filt_tab[i_entry_slot] = new_entry;
                end else begin
                    frames_seen++;
                    scan_frame(i_frame_ident, i_frame_class);
                end
            end
        end
    end

    initial begin : stimulus
        int                 r;
        int                 s;
        caf_pkg::t_mode     md;
        logic [WORD_W-1:0]  wa;
        logic [WORD_W-1:0]  wb;
        logic [WORD_W-1:0]  base;
        logic [CLASS_W-1:0] cl;

        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_kind             = caf_pkg::ITEM_WRITE;
        i_entry_slot       = '0;
        i_entry_enabled    = 1'b0;
        i_entry_mode       = caf_pkg::MODE_MASK;
        i_entry_frame_kind = KIND_STD_DATA;
        i_entry_word_a     = '0;
        i_entry_word_b     = '0;
        i_frame_ident      = '0;
        i_frame_class      = KIND_STD_DATA;
        i_out_stall        = 1'b0;
        for (int k = 0; k < FILTER_SLOTS; k++) begin
            filt_tab[k] = '0;
            gen_a[k]    = '0;
            gen_b[k]    = '0;
            gen_kind[k] = KIND_STD_DATA;
        end

        push_frame('0, KIND_STD_DATA);
        push_write(4'd0, 1'b1, caf_pkg::MODE_MASK, KIND_STD_DATA, '0, '1);
        push_frame(IDENT_MASK[IDENT_W-1:0], KIND_STD_DATA);
        push_write(4'd15, 1'b1, caf_pkg::MODE_LIST, KIND_EXT_DATA, IDENT_MASK, LIST_UNUSED);
        push_frame(IDENT_MASK[IDENT_W-1:0], KIND_EXT_DATA);
        push_frame('0, KIND_EXT_DATA);
        push_write(4'd4, 1'b1, caf_pkg::MODE_LIST, KIND_STD_DATA, 32'h5, 32'h7FF);
        push_frame(29'h7FF, KIND_STD_DATA);
        push_write(4'd7, 1'b1, caf_pkg::MODE_RANGE, KIND_STD_RTR, 32'h100, 32'h1FF);
        push_frame(29'h100, KIND_STD_RTR);
        push_frame(29'h1FF, KIND_STD_RTR);
        push_frame(29'h200, KIND_STD_RTR);
        push_frame(29'h0FF, KIND_STD_RTR);
        // empty range next to a live one
        push_write(4'd8, 1'b1, caf_pkg::MODE_RANGE, KIND_STD_RTR, 32'h200, 32'h100);
        push_frame(29'h180, KIND_STD_RTR);
        push_write(4'd3, 1'b1, caf_pkg::MODE_NONE, KIND_EXT_RTR, '0, '0);
        push_frame('0, KIND_EXT_RTR);
        push_write(4'd3, 1'b0, caf_pkg::MODE_MASK, KIND_EXT_RTR, '0, '0);
        push_frame(29'h123, KIND_EXT_RTR);
        push_write(4'd9, 1'b1, caf_pkg::MODE_MASK, KIND_EXT_RTR, '1, '1);
        push_write(4'd10, 1'b1, caf_pkg::MODE_MASK, KIND_EXT_RTR, IDENT_MASK, 32'h0AAA_AAAA);
        push_frame(29'h0AAA_AAAA, KIND_EXT_RTR);
        push_write(4'd0, 1'b1, caf_pkg::MODE_RANGE, KIND_EXT_DATA, '0, '1);
        push_frame('0, KIND_EXT_DATA);

        // fill the whole table with catch-all entries for a full hit run
        quiet_in = 1'b1;
        for (int k = 0; k < FILTER_SLOTS; k++)
            push_write(SLOT_W'(k), 1'b1, caf_pkg::MODE_MASK, KIND_EXT_RTR, '0, $urandom);
        push_frame(IDENT_W'($urandom), KIND_EXT_RTR);

        for (int k = 0; k < RANDOM_OPS; k++) begin
            quiet_in = (k % 64) >= 48;
            if (k % 90 == 45)
                next_drain = 1'b1;
            s = $urandom_range(0, FILTER_SLOTS - 1);
            if ($urandom_range(0, 99) < 42) begin
                r  = $urandom_range(0, 9);
                md = r < 3 ? caf_pkg::MODE_MASK  :
                     r < 6 ? caf_pkg::MODE_LIST  :
                     r < 9 ? caf_pkg::MODE_RANGE : caf_pkg::MODE_NONE;
                case (md)
                    caf_pkg::MODE_MASK: begin
                        r  = $urandom_range(0, 7);
                        wa = r == 0 ? '0 : r == 1 ? $urandom :
                             r < 4 ? $urandom_range(0, 2047) : $urandom & IDENT_MASK;
                        wb = $urandom_range(0, 3) == 0 ? $urandom : $urandom & IDENT_MASK;
                    end
                    caf_pkg::MODE_LIST: begin
                        r  = $urandom_range(0, 7);
                        wa = r == 0 ? $urandom :
                             r < 4 ? $urandom_range(0, 2047) : $urandom & IDENT_MASK;
                        wb = $urandom_range(0, 3) == 0 ? LIST_UNUSED : $urandom & IDENT_MASK;
                    end
                    caf_pkg::MODE_RANGE: begin
                        base = $urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                    : $urandom & IDENT_MASK;
                        r    = $urandom_range(0, 9);
                        if (r == 0) begin
                            wa = '0;
                            wb = '1;
                        end else if (r == 1) begin
                            wa = base + 1 + $urandom_range(0, 100);
                            wb = base;
                        end else begin
                            wa = base;
                            wb = base + $urandom_range(0, 4000);
                        end
                    end
                    default: begin
                        wa = $urandom;
                        wb = $urandom;
                    end
                endcase
                push_write(SLOT_W'(s), $urandom_range(0, 9) != 0, md,
                           CLASS_W'($urandom_range(0, 3)), wa, wb);
            end else begin
                cl = $urandom_range(0, 4) == 0 ? CLASS_W'($urandom_range(0, 3))
                                               : gen_kind[s];
                case ($urandom_range(0, 9))
                    0, 1:    wa = $urandom;
                    2:       wa = $urandom_range(0, 2047);
                    3, 4:    wa = gen_a[s] + ($urandom_range(0, 1) ? $urandom_range(0, 3000) : 0);
                    5, 6:    wa = gen_b[s];
                    default: wa = (gen_b[s] & gen_a[s]) | ($urandom & ~gen_a[s]);
                endcase
                push_frame(wa[IDENT_W-1:0], cl);
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_taken < ops_total || match_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d entry writes, %0d frames; %0d results checked, %0d of them hits",
                 writes_seen, frames_seen, results_seen, hits_seen);
        $display("longest hit run for one frame: %0d of %0d slots", most_hits, FILTER_SLOTS);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
